/* rtl/pov_sweep_column_timer_core_macros.svh */
// Assertion macros for the sweep column timer core.
// Taken in by the datapath; expects a clock aclk and a reset aresetn in scope.
`ifndef POV_SWEEP_COLUMN_TIMER_CORE_MACROS_SVH
`define POV_SWEEP_COLUMN_TIMER_CORE_MACROS_SVH

// same-cycle implication
`define PVCT_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define PVCT_ASSERT_NXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error(msg);

`endif

/* rtl/pvct_pkg.sv */
// Shared constants, types and helper functions for the sweep column timer.
// No dependencies; imported by the controller, the datapath and the top level.
package pvct_pkg;

    localparam int HISTORY_DEPTH = 10;
    localparam int MAX_COLUMNS   = 255;
    localparam int HIST_MID      = HISTORY_DEPTH / 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_PORCH_PCT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_PORCH_PCT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HALF_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS     = 3'd4;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] RST_ACCEL_INTERVAL  = 16'd78;
    localparam logic [7:0]  RST_FRONT_PORCH_PCT = 8'd80;
    localparam logic [7:0]  RST_BACK_PORCH_PCT  = 8'd120;
    localparam logic [15:0] RST_MAX_HALF_PERIOD = 16'd8000;
    localparam logic [7:0]  RST_NUM_COLUMNS     = 8'd30;

    // half period (< 2^16) times percent (< 2^8)
    localparam int PROD_W = 24;
    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^24
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
    localparam int RPROD_W = PROD_W + RECIP_W;
    localparam int QUOT_W  = RPROD_W - RECIP_SHIFT;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [15:0] PERIOD_NO_COLUMNS = 16'hFFFF;

    typedef struct packed {
        logic accept;
        logic sample;
        logic half;
        logic recip_f;
        logic recip_b;
        logic span;
        logic div;
        logic arm;
        logic disp;
    } pvct_cmd_t;

    typedef struct packed {
        logic trig;
        logic half_ok;
        logic cols_zero;
        logic div_last;
        logic out_free;
    } pvct_stat_t;

    function automatic logic [7:0] cols_used(input logic [7:0] n);
        return (n > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : n;
    endfunction

    function automatic logic is_neg(input logic [5:0] v);
        return v[5];
    endfunction

    function automatic logic is_pos(input logic [5:0] v);
        return !v[5] && (v != 6'd0);
    endfunction

endpackage

/* rtl/pov_sweep_column_timer_core.sv */
// Channel   Dir  Ports                                    Word
// s_        in   s_valid s_ready s_accel_raw               one timer tick
// m_        out  m_valid m_ready m_column_fire ..         one result per tick
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data    register write
//
// A tick samples, then displays; a trigger adds the half-period check, and a
// period within bound adds the two porch reciprocals, span and arm, with the
// 32-step restoring divider for the column period before arm unless zero columns.
// One tick is in flight at a time; the result register lets the next tick be
// accepted while a word waits. A stalled m_ side holds the display step.
// aresetn is synchronous, active low; configuration returns to its defaults.
module pov_sweep_column_timer_core import pvct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_accel_raw,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_column_fire,
    output logic [7:0]            m_column_index,
    output logic                  m_display_blank,
    output logic                  m_sweep_armed,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pvct_cmd_t  cmd;
    pvct_stat_t stat;

    pvct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pvct_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_accel_raw     (s_accel_raw),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_column_fire   (m_column_fire),
        .m_column_index  (m_column_index),
        .m_display_blank (m_display_blank),
        .m_sweep_armed   (m_sweep_armed)
    );

endmodule

/* rtl/pvct_ctrl.sv */
// Sequencer for one tick: sampling, sweep record arithmetic, display step.
// Depends on pvct_pkg for the command and status structs.
module pvct_ctrl import pvct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pvct_stat_t stat,
    output pvct_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SAMPLE  = 4'd1;
    localparam logic [3:0] S_HALF    = 4'd2;
    localparam logic [3:0] S_RECIP_F = 4'd3;
    localparam logic [3:0] S_RECIP_B = 4'd4;
    localparam logic [3:0] S_SPAN    = 4'd5;
    localparam logic [3:0] S_DIV     = 4'd6;
    localparam logic [3:0] S_ARM     = 4'd7;
    localparam logic [3:0] S_DISP    = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_SAMPLE;
            S_SAMPLE:  state_next = stat.trig ? S_HALF : S_DISP;
            S_HALF:    state_next = stat.half_ok ? S_RECIP_F : S_DISP;
            S_RECIP_F: state_next = S_RECIP_B;
            S_RECIP_B: state_next = S_SPAN;
            S_SPAN:    state_next = stat.cols_zero ? S_ARM : S_DIV;
            S_DIV:     if (stat.div_last) state_next = S_ARM;
            S_ARM:     state_next = S_DISP;
            S_DISP:    if (stat.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign cmd.accept  = (state_reg == S_IDLE) && s_valid;
    assign cmd.sample  = (state_reg == S_SAMPLE);
    assign cmd.half    = (state_reg == S_HALF);
    assign cmd.recip_f = (state_reg == S_RECIP_F);
    assign cmd.recip_b = (state_reg == S_RECIP_B);
    assign cmd.span    = (state_reg == S_SPAN);
    assign cmd.div     = (state_reg == S_DIV);
    assign cmd.arm     = (state_reg == S_ARM);
    // display step and result word load happen together, only into a free slot
    assign cmd.disp    = (state_reg == S_DISP) && stat.out_free;

endmodule

/* rtl/pvct_datapath.sv */
// Datapath: config registers, sample/time history, trigger detect, porch math,
// restoring divider, sweep records, column stepping and the result register.
// Depends on pvct_pkg and the assertion macro header.
`include "pov_sweep_column_timer_core_macros.svh"

module pvct_datapath import pvct_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pvct_cmd_t            cmd,
    output pvct_stat_t           stat,
    input  logic [7:0]           s_accel_raw,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_column_fire,
    output logic [7:0]           m_column_index,
    output logic                 m_display_blank,
    output logic                 m_sweep_armed
);

    // configuration
    logic [15:0] accel_interval_reg;
    logic [7:0]  front_pct_reg, back_pct_reg, num_columns_reg;
    logic [15:0] max_half_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_interval_reg <= RST_ACCEL_INTERVAL;
            front_pct_reg      <= RST_FRONT_PORCH_PCT;
            back_pct_reg       <= RST_BACK_PORCH_PCT;
            max_half_reg       <= RST_MAX_HALF_PERIOD;
            num_columns_reg    <= RST_NUM_COLUMNS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ACCEL_INTERVAL:  accel_interval_reg <= cfg_data;
                CFG_FRONT_PORCH_PCT: front_pct_reg      <= cfg_data[7:0];
                CFG_BACK_PORCH_PCT:  back_pct_reg       <= cfg_data[7:0];
                CFG_MAX_HALF_PERIOD: max_half_reg       <= cfg_data;
                CFG_NUM_COLUMNS:     num_columns_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [7:0] cols_n;
    assign cols_n = cols_used(num_columns_reg);

    // sampling state
    logic [7:0]  raw_reg;
    logic [31:0] tick_reg, last_sample_reg;
    logic [5:0]  sample_hist_reg [HISTORY_DEPTH];
    logic [31:0] time_hist_reg   [HISTORY_DEPTH];
    logic        moving_left_reg;
    logic [31:0] trig_time_reg, prev_trig_reg;
    logic        armed_reg;

    logic [31:0] since_sample;
    logic        take, keep, rise, fall, trig;
    logic [5:0]  new_sample;

    assign since_sample = tick_reg - last_sample_reg;
    assign take         = since_sample > {16'd0, accel_interval_reg};
    assign keep         = take && !raw_reg[6];
    assign new_sample   = raw_reg[5:0];

    // evaluated on the history as it stands before this shift, with the new sample
    assign rise = is_neg(sample_hist_reg[1]) && is_neg(sample_hist_reg[2])
               && is_neg(sample_hist_reg[3]) && is_pos(new_sample)
               && is_pos(sample_hist_reg[HISTORY_DEPTH-1])
               && is_pos(sample_hist_reg[HISTORY_DEPTH-2]);
    assign fall = is_pos(sample_hist_reg[1]) && is_pos(sample_hist_reg[2])
               && is_pos(sample_hist_reg[3]) && is_neg(new_sample)
               && is_neg(sample_hist_reg[HISTORY_DEPTH-1])
               && is_neg(sample_hist_reg[HISTORY_DEPTH-2]);
    assign trig = keep && ((!moving_left_reg && rise) || (moving_left_reg && fall));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg        <= 32'd0;
            last_sample_reg <= 32'd0;
            moving_left_reg <= 1'b0;
            trig_time_reg   <= 32'd0;
            prev_trig_reg   <= 32'd0;
            armed_reg       <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                sample_hist_reg[i] <= 6'd0;
                time_hist_reg[i]   <= 32'd0;
            end
        end else begin
            if (cmd.accept) begin
                raw_reg   <= s_accel_raw;
                tick_reg  <= tick_reg + 32'd1;
                armed_reg <= 1'b0;
            end
            if (cmd.sample && take) begin
                last_sample_reg <= tick_reg;
            end
            if (cmd.sample && keep) begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                    sample_hist_reg[i] <= sample_hist_reg[i+1];
                    time_hist_reg[i]   <= time_hist_reg[i+1];
                end
                sample_hist_reg[HISTORY_DEPTH-1] <= new_sample;
                time_hist_reg[HISTORY_DEPTH-1]   <= tick_reg;
            end
            if (cmd.sample && trig) begin
                moving_left_reg <= !moving_left_reg;
                prev_trig_reg   <= trig_time_reg;
                trig_time_reg   <= time_hist_reg[HIST_MID+1];
            end
            if (cmd.arm) begin
                armed_reg <= 1'b1;
            end
        end
    end

    // porch arithmetic
    logic [31:0]        half;
    logic               half_ok;
    logic [PROD_W-1:0]  prod_front_reg, prod_back_reg, recip_in;
    logic [RPROD_W-1:0] recip_prod;
    logic [QUOT_W-1:0]  q_front_reg, q_back_reg;
    logic [31:0]        first_reg;

    assign half       = trig_time_reg - prev_trig_reg;
    assign half_ok    = half < {16'd0, max_half_reg};
    assign recip_in   = cmd.recip_b ? prod_back_reg : prod_front_reg;
    assign recip_prod = RPROD_W'(recip_in) * RPROD_W'(RECIP_100);

    always_ff @(posedge aclk) begin
        if (cmd.half) begin
            prod_front_reg <= PROD_W'(half[15:0]) * PROD_W'(front_pct_reg);
            prod_back_reg  <= PROD_W'(half[15:0]) * PROD_W'(back_pct_reg);
        end
        if (cmd.recip_f) begin
            q_front_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (cmd.recip_b) begin
            q_back_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (cmd.span) begin
            first_reg <= trig_time_reg + 32'(q_front_reg);
        end
    end

    // restoring divider: span / columns, one quotient bit a cycle
    logic [31:0]          div_q_reg;
    logic [8:0]           div_rem_reg, rem_sh;
    logic                 rem_ge;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    assign rem_sh = {div_rem_reg[7:0], div_q_reg[31]};
    assign rem_ge = rem_sh >= {1'b0, cols_n};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.span) begin
            div_cnt_reg <= '0;
        end else if (cmd.div) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.span) begin
            // trigger time cancels out of (last - first)
            div_q_reg   <= 32'(q_back_reg) - 32'(q_front_reg);
            div_rem_reg <= 9'd0;
        end else if (cmd.div) begin
            div_q_reg   <= {div_q_reg[30:0], rem_ge};
            div_rem_reg <= rem_ge ? (rem_sh - {1'b0, cols_n}) : rem_sh;
        end
    end

    // sweep records and display stepping
    logic [31:0] rec_start_reg  [2];
    logic [15:0] rec_period_reg [2];
    logic        rec_fwd_reg    [2];
    logic        rec_valid_reg  [2];
    logic        active_rec_reg;
    logic [31:0] next_col_reg;
    logic [15:0] period_now_reg;
    logic [7:0]  cur_col_reg, cols_left_reg;
    logic        step_fwd_reg, disp_active_reg;

    logic        fire, blank, rec_sel, due, start_due;
    logic [7:0]  fire_idx;

    assign rec_sel   = active_rec_reg;
    assign due       = tick_reg >= next_col_reg;
    assign start_due = rec_valid_reg[rec_sel] && (tick_reg >= rec_start_reg[rec_sel]);
    assign fire      = disp_active_reg && due;
    assign fire_idx  = fire ? cur_col_reg : 8'd0;
    assign blank     = fire && (cols_left_reg == 8'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rec_reg  <= 1'b0;
            next_col_reg    <= 32'd0;
            period_now_reg  <= 16'd0;
            cur_col_reg     <= 8'd0;
            cols_left_reg   <= 8'd0;
            step_fwd_reg    <= 1'b0;
            disp_active_reg <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                rec_start_reg[i]  <= 32'd0;
                rec_period_reg[i] <= 16'd0;
                rec_fwd_reg[i]    <= 1'b0;
                rec_valid_reg[i]  <= 1'b0;
            end
        end else begin
            if (cmd.arm) begin
                active_rec_reg                  <= !active_rec_reg;
                rec_start_reg[!active_rec_reg]  <= first_reg;
                rec_period_reg[!active_rec_reg] <= (cols_n == 8'd0) ? PERIOD_NO_COLUMNS
                                                                    : div_q_reg[15:0];
                rec_fwd_reg[!active_rec_reg]    <= moving_left_reg;
                rec_valid_reg[!active_rec_reg]  <= 1'b1;
            end
            if (cmd.disp) begin
                if (disp_active_reg) begin
                    if (due) begin
                        next_col_reg  <= next_col_reg + 32'(period_now_reg);
                        cur_col_reg   <= step_fwd_reg ? cur_col_reg + 8'd1
                                                      : cur_col_reg - 8'd1;
                        cols_left_reg <= cols_left_reg - 8'd1;
                        if (cols_left_reg == 8'd1) begin
                            disp_active_reg <= 1'b0;
                        end
                    end
                end else if (start_due) begin
                    rec_valid_reg[rec_sel] <= 1'b0;
                    if (cols_n != 8'd0) begin
                        cols_left_reg   <= cols_n;
                        next_col_reg    <= rec_start_reg[rec_sel]
                                         + 32'(rec_period_reg[rec_sel]);
                        period_now_reg  <= rec_period_reg[rec_sel];
                        step_fwd_reg    <= rec_fwd_reg[rec_sel];
                        cur_col_reg     <= rec_fwd_reg[rec_sel] ? 8'd0 : cols_n - 8'd1;
                        disp_active_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // result word register
    logic       m_valid_reg;
    logic       m_fire_reg, m_blank_reg, m_armed_reg;
    logic [7:0] m_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.disp) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.disp) begin
            m_fire_reg  <= fire;
            m_index_reg <= fire_idx;
            m_blank_reg <= blank;
            m_armed_reg <= armed_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_column_fire   = m_fire_reg;
    assign m_column_index  = m_index_reg;
    assign m_display_blank = m_blank_reg;
    assign m_sweep_armed   = m_armed_reg;

    assign stat.trig      = trig;
    assign stat.half_ok   = half_ok;
    assign stat.cols_zero = (cols_n == 8'd0);
    assign stat.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    `PVCT_ASSERT_IMP(a_blank_needs_fire, m_valid_reg && m_blank_reg, m_fire_reg, "blank without fire")
    `PVCT_ASSERT_IMP(a_active_has_cols, disp_active_reg, cols_left_reg != 8'd0, "active sweep, no columns")
    `PVCT_ASSERT_IMP(a_div_nonzero, cmd.div, cols_n != 8'd0, "divide by zero columns")
    `PVCT_ASSERT_NXT(a_disp_loads_out, cmd.disp, m_valid_reg, "display step lost its word")
    `PVCT_ASSERT_IMP(a_out_from_disp, $rose(m_valid_reg), $past(cmd.disp), "result word from nowhere")

endmodule
